@@ design/bclpd_pkg.sv @@
// shared types and constants for the button click and long-press detector
package bclpd_pkg;

  // raw level pins carried by one sample
  localparam int NUM_LEVELS = 4;
  localparam int BTN_W      = $clog2(NUM_LEVELS);
  localparam int TIME_W     = 32;

  localparam logic LEVEL_RELEASED = 1'b1;

  localparam logic KIND_CLICK = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  // configuration register map, word addressed
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS_MS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_MS       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLICK_ENABLE      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS_ENABLE = 2'd3;

  localparam logic [15:0] LONG_PRESS_MS_RESET = 16'd1500;
  localparam logic [7:0]  DEBOUNCE_MS_RESET   = 8'd20;

  // event queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [NUM_LEVELS-1:0] levels;
    logic [TIME_W-1:0]     time_ms;
  } in_t;

  typedef struct packed {
    logic [BTN_W-1:0] button;
    logic             kind;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [7:0]  debounce_ms;
    logic        click_en;
    logic        long_en;
  } cfg_t;

  // events of one sample: one bit per button, kind alongside
  typedef struct packed {
    logic [NUM_LEVELS-1:0] hit;
    logic [NUM_LEVELS-1:0] kind;
  } ev_batch_t;

endpackage

@@ design/bclpd_front.sv @@
// front end: per-button debounce and press timing, one sample per cycle while the queue is not full
module bclpd_front #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bclpd_pkg::in_t        in_data,
  input  bclpd_pkg::cfg_t       cfg,
  input  logic                  q_full,
  output logic                  q_push,
  output bclpd_pkg::ev_batch_t  q_batch
);
  import bclpd_pkg::*;

  logic                   accept;
  logic [NUM_BUTTONS-1:0] lane_hit;
  logic [NUM_BUTTONS-1:0] lane_kind;
  logic [NUM_LEVELS-1:0]  hit_v;
  logic [NUM_LEVELS-1:0]  kind_v;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    logic              lvl;
    logic              acc_level_r, acc_level_nxt;
    logic              held_r, held_nxt;
    logic              long_seen_r, long_seen_nxt;
    logic [TIME_W-1:0] change_time_r, change_time_nxt;
    logic [TIME_W-1:0] press_time_r, press_time_nxt;
    logic [TIME_W-1:0] since_change, since_press, hold_time;
    logic              deb_ok, chg, start, release_held, click, long_hit;

    // buttons with no pin stay released
    if (g < NUM_LEVELS) begin : g_pin
      assign lvl = in_data.levels[g];
    end else begin : g_nopin
      assign lvl = LEVEL_RELEASED;
    end

    always_comb begin
      since_change    = in_data.time_ms - change_time_r;
      since_press     = in_data.time_ms - press_time_r;
      deb_ok          = since_change >= {{(TIME_W-8){1'b0}}, cfg.debounce_ms};
      chg             = deb_ok && (lvl != acc_level_r);
      start           = chg && (lvl != LEVEL_RELEASED) && !held_r;
      release_held    = chg && (lvl == LEVEL_RELEASED) && held_r;
      click           = release_held && !long_seen_r && cfg.click_en &&
                        (since_press < {{(TIME_W-16){1'b0}}, cfg.long_press_ms});
      acc_level_nxt   = chg ? lvl : acc_level_r;
      change_time_nxt = chg ? in_data.time_ms : change_time_r;
      held_nxt        = held_r;
      long_seen_nxt   = long_seen_r;
      press_time_nxt  = press_time_r;
      if (start) begin
        held_nxt       = 1'b1;
        long_seen_nxt  = 1'b0;
        press_time_nxt = in_data.time_ms;
      end
      if (release_held) begin
        held_nxt       = 1'b0;
        long_seen_nxt  = 1'b0;
        press_time_nxt = '0;
      end
      // a press taken in this sample has been held for zero ms
      hold_time = start ? '0 : since_press;
      long_hit  = held_nxt && !long_seen_nxt &&
                  (hold_time >= {{(TIME_W-16){1'b0}}, cfg.long_press_ms});
      if (long_hit) begin
        long_seen_nxt = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_level_r   <= LEVEL_RELEASED;
        held_r        <= 1'b0;
        long_seen_r   <= 1'b0;
        change_time_r <= '0;
        press_time_r  <= '0;
      end else if (accept) begin
        acc_level_r   <= acc_level_nxt;
        held_r        <= held_nxt;
        long_seen_r   <= long_seen_nxt;
        change_time_r <= change_time_nxt;
        press_time_r  <= press_time_nxt;
      end
    end

    assign lane_hit[g]  = click || (long_hit && cfg.long_en);
    assign lane_kind[g] = long_hit ? KIND_LONG : KIND_CLICK;
  end

  for (genvar j = 0; j < NUM_LEVELS; j++) begin : g_map
    if (j < NUM_BUTTONS) begin : g_on
      assign hit_v[j]  = lane_hit[j];
      assign kind_v[j] = lane_kind[j];
    end else begin : g_off
      assign hit_v[j]  = 1'b0;
      assign kind_v[j] = KIND_CLICK;
    end
  end

  assign q_batch = '{hit: hit_v, kind: kind_v};
  // samples without events leave nothing in the queue
  assign q_push  = accept && (|hit_v);

endmodule

@@ design/bclpd_queue.sv @@
// short queue of per-sample event batches between front and back
module bclpd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bclpd_pkg::ev_batch_t  push_data,
  input  logic                  pop,
  output bclpd_pkg::ev_batch_t  head,
  output logic                  full,
  output logic                  empty
);
  import bclpd_pkg::*;

  ev_batch_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign head  = mem[rd_ptr_r];
  assign full  = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = count_r == '0;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ design/bclpd_back.sv @@
// back end: walks a batch in button order, one event per cycle into the output register unless stalled
module bclpd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  bclpd_pkg::ev_batch_t  q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bclpd_pkg::out_t       out_data
);
  import bclpd_pkg::*;

  logic [NUM_LEVELS-1:0] pend_r, pend_nxt;
  logic [NUM_LEVELS-1:0] kind_r, kind_nxt;
  logic [NUM_LEVELS-1:0] rest;
  logic [BTN_W-1:0]      sel;
  logic                  load, last;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  always_comb begin
    sel = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = BTN_W'(i);
      end
    end
    rest = pend_r & ~(NUM_LEVELS'(1) << sel);
    last = rest == '0;
    load = (|pend_r) && (!out_valid_r || out_ready);
    // refill as the last event of the current batch leaves
    q_pop = !q_empty && ((pend_r == '0) || (load && last));

    pend_nxt = pend_r;
    kind_nxt = kind_r;
    if (q_pop) begin
      pend_nxt = q_head.hit;
      kind_nxt = q_head.kind;
    end else if (load) begin
      pend_nxt = rest;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{button: sel, kind: kind_r[sel], last: last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/button_click_long_press_detector.sv @@
// top level: configuration registers, front end, event queue and back end
//
//  port group  | direction | handshake          | payload
//  in_         | input     | in_valid/in_ready  | levels, time_ms
//  out_        | output    | out_valid/out_ready| button, kind, last
//  apb         | both      | psel/penable       | 4 registers at 0x0, 0x4, 0x8, 0xc
//
// the front end takes a sample every cycle while the queue has room and updates
// all buttons at once; the back end gives one event per cycle unless out_ready
// holds it back; a sample gives up to 4 events, and one with none never reaches the queue
// events move from a queue entry to the pending batch register, then to out_data
// synchronous active-low reset clears button state and loads register defaults
// output stalls fill the two-entry queue, then in_ready drops
module button_click_long_press_detector #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  bclpd_pkg::in_t                         in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output bclpd_pkg::out_t                        out_data,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [bclpd_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [bclpd_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [bclpd_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                   pready
);
  import bclpd_pkg::*;

  logic [15:0]          long_press_ms_r;
  logic [7:0]           debounce_ms_r;
  logic                 click_enable_r;
  logic                 long_press_enable_r;
  logic                 reg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  cfg_t                 cfg;
  logic                 q_push, q_pop, q_full, q_empty;
  ev_batch_t            q_batch, q_head;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_ms_r     <= LONG_PRESS_MS_RESET;
      debounce_ms_r       <= DEBOUNCE_MS_RESET;
      click_enable_r      <= 1'b0;
      long_press_enable_r <= 1'b0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_LONG_PRESS_MS:     long_press_ms_r     <= pwdata[15:0];
        REG_DEBOUNCE_MS:       debounce_ms_r       <= pwdata[7:0];
        REG_CLICK_ENABLE:      click_enable_r      <= pwdata[0];
        REG_LONG_PRESS_ENABLE: long_press_enable_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LONG_PRESS_MS:     prdata = {16'd0, long_press_ms_r};
      REG_DEBOUNCE_MS:       prdata = {24'd0, debounce_ms_r};
      REG_CLICK_ENABLE:      prdata = {31'd0, click_enable_r};
      REG_LONG_PRESS_ENABLE: prdata = {31'd0, long_press_enable_r};
      default:               prdata = '0;
    endcase
  end

  assign cfg = '{long_press_ms: long_press_ms_r, debounce_ms: debounce_ms_r,
                 click_en: click_enable_r, long_en: long_press_enable_r};

  bclpd_front #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_batch  (q_batch)
  );

  bclpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_batch),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  bclpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("event batch pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("event batch popped from an empty queue");

  a_batch_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |=> out_valid)
    else $error("batch ended without an event marked last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

@@ test/tb_button_click_long_press_detector.sv @@
// testbench for the button click and long-press detector: directed table, random polls, scoreboard
module tb_button_click_long_press_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import bclpd_pkg::*;

  localparam int NUM_BUTTONS   = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_ITEMS   = 48;
  localparam int BURST_ITEMS   = 24;

  typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_e;
  typedef enum {WANT_MODEL, WANT_NONE, WANT_ONE} want_e;

  typedef struct {
    row_kind_e             kind;
    logic [NUM_LEVELS-1:0] levels;
    logic [31:0]           value;
    want_e                 want;
    logic [BTN_W-1:0]      btn;
    logic                  ev_kind;
    logic [REG_IDX_W-1:0]  idx;
  } row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // register shadow
  logic [15:0] lp_ms;
  logic [7:0]  deb_ms;
  logic        click_on;
  logic        long_on;

  // per-button debounce and press tracking
  logic        acc_level [NUM_BUTTONS];
  logic [31:0] chg_time  [NUM_BUTTONS];
  logic        held      [NUM_BUTTONS];
  logic        long_seen [NUM_BUTTONS];
  logic [31:0] press_t   [NUM_BUTTONS];

  out_t step_evs[$];
  out_t pending_events[$];
  row_t dir_rows[$];

  int n_fail     = 0;
  int n_checked  = 0;
  int n_sent     = 0;
  int n_settings = 0;
  int in_stalls  = 0;

  int  rx_left     = 0;
  int  hold_asked  = 0;
  int  hold_done   = 0;
  bit  rx_eager    = 1'b0;
  bit  tx_eager    = 1'b0;
  logic [31:0] cur_t;

  button_click_long_press_detector #(.NUM_BUTTONS(NUM_BUTTONS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
  endfunction

  // receiver: random stalls, a long hold when asked, or always ready
  always @(posedge clk) begin
    if (hold_asked != hold_done) begin
      hold_done <= hold_asked;
      out_ready <= 1'b0;
      rx_left   <= HOLD_CYCLES;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (rx_eager) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_left   <= gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
      rx_left   <= $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    if (in_valid && !in_ready) in_stalls++;
  end

  // scoreboard: each event against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (pending_events.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected event: button %0d kind %0d last %0d",
                   out_data.button, out_data.kind, out_data.last);
      end else begin
        want = pending_events.pop_front();
        if (out_data.button !== want.button || out_data.kind !== want.kind ||
            out_data.last !== want.last) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: expected button %0d kind %0d last %0d, got button %0d kind %0d last %0d",
                     want.button, want.kind, want.last,
                     out_data.button, out_data.kind, out_data.last);
        end
      end
    end
  end

  function automatic void clear_buttons();
    lp_ms    = LONG_PRESS_MS_RESET;
    deb_ms   = DEBOUNCE_MS_RESET;
    click_on = 1'b0;
    long_on  = 1'b0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      acc_level[b] = LEVEL_RELEASED;
      chg_time[b]  = '0;
      held[b]      = 1'b0;
      long_seen[b] = 1'b0;
      press_t[b]   = '0;
    end
  endfunction

  // events that one poll sample gives, in button order
  function automatic void step_buttons(in_t s);
    logic        lv;
    logic [31:0] dt;
    logic        hit;
    out_t        e;
    step_evs.delete();
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      lv    = (b < NUM_LEVELS) ? s.levels[b] : LEVEL_RELEASED;
      hit   = 1'b0;
      e     = '0;
      e.button = b[BTN_W-1:0];
      dt = s.time_ms - chg_time[b];
      if (dt >= {24'd0, deb_ms} && lv != acc_level[b]) begin
        chg_time[b]  = s.time_ms;
        acc_level[b] = lv;
        if (lv != LEVEL_RELEASED) begin
          if (!held[b]) begin
            held[b]      = 1'b1;
            press_t[b]   = s.time_ms;
            long_seen[b] = 1'b0;
          end
        end else if (held[b]) begin
          dt = s.time_ms - press_t[b];
          if (!long_seen[b] && click_on && dt < {16'd0, lp_ms}) begin
            hit    = 1'b1;
            e.kind = KIND_CLICK;
          end
          held[b]      = 1'b0;
          long_seen[b] = 1'b0;
          press_t[b]   = '0;
        end
      end
      dt = s.time_ms - press_t[b];
      if (held[b] && !long_seen[b] && dt >= {16'd0, lp_ms}) begin
        long_seen[b] = 1'b1;
        if (long_on) begin
          hit    = 1'b1;
          e.kind = KIND_LONG;
        end
      end
      if (hit) step_evs.push_back(e);
    end
    if (step_evs.size() > 0) step_evs[step_evs.size()-1].last = 1'b1;
  endfunction

  function automatic row_t smp(logic [NUM_LEVELS-1:0] lv, logic [31:0] t,
                               want_e w = WANT_MODEL, logic [BTN_W-1:0] b = '0,
                               logic k = KIND_CLICK);
    row_t r;
    r.kind    = ROW_SAMPLE;
    r.levels  = lv;
    r.value   = t;
    r.want    = w;
    r.btn     = b;
    r.ev_kind = k;
    r.idx     = '0;
    return r;
  endfunction

  function automatic row_t wr(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
    row_t r;
    r       = smp('0, v);
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    return r;
  endfunction

  // offer one sample, wait for the request to be taken, then predict
  task automatic offer(in_t s, bit keep_model);
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    step_buttons(s);
    if (keep_model)
      foreach (step_evs[k]) pending_events.push_back(step_evs[k]);
  endtask

  task automatic tx_pause();
    if (!tx_eager && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // idle the sender and let every expected event come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LONG_PRESS_MS:     lp_ms    = val[15:0];
      REG_DEBOUNCE_MS:       deb_ms   = val[7:0];
      REG_CLICK_ENABLE:      click_on = val[0];
      REG_LONG_PRESS_ENABLE: long_on  = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] lp, logic [7:0] deb, logic ce, logic le);
    settle();
    reg_write(REG_LONG_PRESS_MS, {16'd0, lp});
    reg_write(REG_DEBOUNCE_MS, {24'd0, deb});
    reg_write(REG_CLICK_ENABLE, {31'd0, ce});
    reg_write(REG_LONG_PRESS_ENABLE, {31'd0, le});
    n_settings++;
  endtask

  // random walk of button levels with bounce, time jumps and noise samples
  task automatic run_phase(int items);
    in_t                   s;
    logic [NUM_LEVELS-1:0] pin;
    pin = '1;
    for (int i = 0; i < items; i++) begin
      int r;
      r = $urandom_range(0, 24);
      if (r == 0) begin
        s.levels  = NUM_LEVELS'($urandom);
        s.time_ms = $urandom;
        cur_t     = s.time_ms;
      end else begin
        for (int b = 0; b < NUM_LEVELS; b++)
          if ($urandom_range(0, 7) == 0) pin[b] = ~pin[b];
        s.levels = pin;
        if (r == 1) s.levels[BTN_W'($urandom_range(0, NUM_LEVELS-1))] ^= 1'b1;
        if (r == 2)
          cur_t += $urandom_range(0, 70000);
        else if (r < 6)
          cur_t += $urandom_range(0, 30);
        else
          cur_t += 10;
        s.time_ms = cur_t;
      end
      offer(s, 1'b1);
      tx_pause();
    end
  endtask

  initial begin
    in_t  s;
    out_t e;

    clear_buttons();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: clicks and long presses both muted
    dir_rows.push_back(smp(4'hF, 32'd0, WANT_NONE));
    dir_rows.push_back(smp(4'hE, 32'd100, WANT_NONE));
    dir_rows.push_back(smp(4'hF, 32'd200, WANT_NONE));
    dir_rows.push_back(wr(REG_CLICK_ENABLE, 32'd1));
    dir_rows.push_back(wr(REG_LONG_PRESS_ENABLE, 32'd1));
    dir_rows.push_back(wr(REG_LONG_PRESS_MS, 32'd100));
    dir_rows.push_back(smp(4'hE, 32'd300, WANT_NONE));
    // bounce inside the debounce window is ignored
    dir_rows.push_back(smp(4'hF, 32'd310, WANT_NONE));
    dir_rows.push_back(smp(4'hF, 32'd350, WANT_ONE, 2'd0, KIND_CLICK));
    dir_rows.push_back(smp(4'h0, 32'd400, WANT_NONE));
    dir_rows.push_back(smp(4'h0, 32'd500));
    dir_rows.push_back(smp(4'hF, 32'd600, WANT_NONE));
    dir_rows.push_back(smp(4'h7, 32'd700, WANT_NONE));
    dir_rows.push_back(smp(4'hF, 32'd710, WANT_NONE));
    dir_rows.push_back(smp(4'hF, 32'd720, WANT_ONE, 2'd3, KIND_CLICK));
    // zero threshold: long press in the sample that takes the press
    dir_rows.push_back(wr(REG_LONG_PRESS_MS, 32'd0));
    dir_rows.push_back(smp(4'hB, 32'd800, WANT_ONE, 2'd2, KIND_LONG));
    dir_rows.push_back(smp(4'hF, 32'd900, WANT_NONE));
    dir_rows.push_back(wr(REG_LONG_PRESS_MS, 32'd65535));
    dir_rows.push_back(wr(REG_DEBOUNCE_MS, 32'd255));
    dir_rows.push_back(smp(4'hD, 32'd1000, WANT_NONE));
    dir_rows.push_back(smp(4'hF, 32'd1100, WANT_NONE));
    dir_rows.push_back(smp(4'hF, 32'd1255, WANT_ONE, 2'd1, KIND_CLICK));
    // time wraps across the hold
    dir_rows.push_back(smp(4'hE, 32'hFFFF_FF00, WANT_NONE));
    dir_rows.push_back(smp(4'hF, 32'h0000_0010, WANT_ONE, 2'd0, KIND_CLICK));
    dir_rows.push_back(smp(4'h0, 32'h0000_1000, WANT_NONE));
    dir_rows.push_back(smp(4'h0, 32'h0001_0FFF));
    dir_rows.push_back(smp(4'hF, 32'h0001_13E7, WANT_NONE));
    dir_rows.push_back(wr(REG_DEBOUNCE_MS, 32'd0));
    dir_rows.push_back(smp(4'h5, 32'h0003_0000, WANT_NONE));
    dir_rows.push_back(smp(4'hA, 32'h0003_0001));
    dir_rows.push_back(smp(4'hF, 32'h0003_0001));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        reg_write(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        s.levels  = dir_rows[i].levels;
        s.time_ms = dir_rows[i].value;
        offer(s, dir_rows[i].want == WANT_MODEL);
        if (dir_rows[i].want == WANT_ONE) begin
          e.button = dir_rows[i].btn;
          e.kind   = dir_rows[i].ev_kind;
          e.last   = 1'b1;
          pending_events.push_back(e);
        end
        tx_pause();
      end
    end

    cur_t = 32'h0004_0000;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_all(16'd0, 8'd0, 1'b1, 1'b1);
        1: set_all(16'd65535, 8'd255, 1'b1, 1'b1);
        3: set_all(16'($urandom_range(20, 400)), 8'($urandom_range(0, 40)), 1'b0, 1'b1);
        4: set_all(16'($urandom_range(20, 400)), 8'($urandom_range(0, 40)), 1'b1, 1'b0);
        6: set_all(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 1'b1, 1'b1);
        7: set_all(16'($urandom_range(20, 400)), 8'($urandom_range(0, 40)), 1'b0, 1'b0);
        default: set_all(16'($urandom_range(20, 400)), 8'($urandom_range(0, 40)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      // one stretch with no idling on either side
      rx_eager <= (p == 2);
      tx_eager  = (p == 2);
      if (p == 5) cur_t = 32'hFFFF_FF00;
      run_phase(PHASE_ITEMS);
    end
    rx_eager <= 1'b0;
    tx_eager  = 1'b0;

    // receiver holds off while the sender keeps pressing and releasing all buttons
    set_all(16'd65535, 8'd5, 1'b1, 1'b1);
    tx_eager = 1'b1;
    hold_asked <= hold_asked + 1;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      cur_t += 10;
      s.levels  = (i % 2 == 0) ? 4'h0 : 4'hF;
      s.time_ms = cur_t;
      offer(s, 1'b1);
    end
    tx_eager = 1'b0;
    settle();

    $display("%0d poll samples sent, %0d events checked, %0d register settings",
             n_sent, n_checked, n_settings);
    $display("input held back for %0d cycles by output back-pressure", in_stalls);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
